FILE: sv/ckc_pkg.sv
package ckc_pkg;

  localparam int unsigned PixelWidth = 8;
  localparam int unsigned CoordWidth = 11;
  localparam int unsigned SumWidth = 34;
  localparam int unsigned CountWidth = 23;
  localparam int unsigned QuoWidth = 15;
  localparam int unsigned FracBits = 4;
  localparam int unsigned StepWidth = 4;
  localparam int unsigned MaxSide = 2048;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [PixelWidth-1:0] TolReset = 8'd5;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrWidth = $clog2(QueueDepth);
  localparam int unsigned FillWidth = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    CFG_TARGET_RED   = 2'd0,
    CFG_TARGET_GREEN = 2'd1,
    CFG_TARGET_BLUE  = 2'd2,
    CFG_MATCH_TOL    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_OUTPUT
  } back_state_e;

  typedef struct packed {
    logic [PixelWidth-1:0] pixel_blue;
    logic [PixelWidth-1:0] pixel_green;
    logic [PixelWidth-1:0] pixel_red;
    logic [CoordWidth-1:0] column;
    logic [CoordWidth-1:0] row_index;
    logic                  last_pixel;
  } pixel_beat_t;

  typedef struct packed {
    logic [QuoWidth-1:0]   centroid_x;
    logic [QuoWidth-1:0]   centroid_y;
    logic [CountWidth-1:0] match_count;
    logic                  found;
  } result_beat_t;

  typedef struct packed {
    logic [SumWidth-1:0]   column_sum;
    logic [SumWidth-1:0]   row_sum;
    logic [CountWidth-1:0] pixel_matches;
  } frame_sums_t;

  typedef struct packed {
    logic [PixelWidth-1:0] target_red;
    logic [PixelWidth-1:0] target_green;
    logic [PixelWidth-1:0] target_blue;
    logic [PixelWidth-1:0] match_tolerance;
  } key_cfg_t;

endpackage

FILE: sv/ckc_front.sv
module ckc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ckc_pkg::key_cfg_t    cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ckc_pkg::pixel_beat_t in_beat_i,
  output logic                 push_o,
  output ckc_pkg::frame_sums_t push_data_o,
  input  logic                 full_i
);

  logic                                s1_valid_q, s1_valid_d;
  logic                                s1_match_q, s1_match_d;
  logic                                s1_last_q;
  logic [ckc_pkg::CoordWidth-1:0]      s1_col_q, s1_row_q;
  ckc_pkg::frame_sums_t                acc_q, acc_d, acc_next;
  logic                                accept;
  logic                                advance;
  logic                                in_side;

  function automatic logic close_enough(input logic [ckc_pkg::PixelWidth-1:0] pix,
                                        input logic [ckc_pkg::PixelWidth-1:0] tgt,
                                        input logic [ckc_pkg::PixelWidth-1:0] tol);
    logic [ckc_pkg::PixelWidth-1:0] diff;
    diff = (pix >= tgt) ? (pix - tgt) : (tgt - pix);
    return diff < tol;
  endfunction

  assign advance    = s1_valid_q && (!s1_last_q || !full_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign in_side = (32'(in_beat_i.column) < ckc_pkg::MaxSide)
                && (32'(in_beat_i.row_index) < ckc_pkg::MaxSide);

  always_comb begin
    s1_valid_d = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    s1_match_d = in_side
              && close_enough(in_beat_i.pixel_blue, cfg_i.target_blue, cfg_i.match_tolerance)
              && close_enough(in_beat_i.pixel_green, cfg_i.target_green,
                              cfg_i.match_tolerance)
              && close_enough(in_beat_i.pixel_red, cfg_i.target_red, cfg_i.match_tolerance);
  end

  // running sums with the staged pixel folded in
  always_comb begin
    acc_next = acc_q;
    if (s1_match_q && (acc_q.pixel_matches != ckc_pkg::CountMax)) begin
      acc_next.column_sum    = acc_q.column_sum + ckc_pkg::SumWidth'(s1_col_q);
      acc_next.row_sum       = acc_q.row_sum + ckc_pkg::SumWidth'(s1_row_q);
      acc_next.pixel_matches = acc_q.pixel_matches + 1'b1;
    end
    acc_d = acc_q;
    if (advance) begin
      acc_d = s1_last_q ? '0 : acc_next;
    end
  end

  assign push_o      = advance && s1_last_q;
  assign push_data_o = acc_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_match_q <= s1_match_d;
      s1_last_q  <= in_beat_i.last_pixel;
      s1_col_q   <= in_beat_i.column;
      s1_row_q   <= in_beat_i.row_index;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (acc_q.pixel_matches == '0) && (acc_q.column_sum == '0))
    else $error("sums not cleared after frame end");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("frame pushed into full queue");

endmodule

FILE: sv/ckc_queue.sv
module ckc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ckc_pkg::frame_sums_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output ckc_pkg::frame_sums_t pop_data_o,
  output logic                 empty_o
);

  ckc_pkg::frame_sums_t             mem_q [ckc_pkg::QueueDepth];
  logic [ckc_pkg::PtrWidth-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ckc_pkg::FillWidth-1:0]    fill_q, fill_d;

  function automatic logic [ckc_pkg::PtrWidth-1:0] ptr_inc(
      input logic [ckc_pkg::PtrWidth-1:0] p);
    if (p == ckc_pkg::PtrWidth'(ckc_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full_o     = fill_q == ckc_pkg::FillWidth'(ckc_pkg::QueueDepth);
  assign empty_o    = fill_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

FILE: sv/ckc_back.sv
module ckc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ckc_pkg::frame_sums_t  sums_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ckc_pkg::result_beat_t out_beat_o
);

  localparam int unsigned DivWidth = ckc_pkg::SumWidth + ckc_pkg::FracBits;

  ckc_pkg::back_state_e              state_q, state_d;
  logic [ckc_pkg::QuoWidth-1:0]      dx_q, dy_q;
  logic [ckc_pkg::CountWidth-1:0]    rx_q, ry_q, div_q;
  logic [ckc_pkg::StepWidth-1:0]     step_q;
  logic                              found_q;
  logic [DivWidth-1:0]               dvx, dvy;
  logic [ckc_pkg::CountWidth:0]      tx, ty, dext;
  logic                              gx, gy;
  logic                              last_step;
  logic                              load;

  assign dvx       = {sums_i.column_sum, ckc_pkg::FracBits'(0)};
  assign dvy       = {sums_i.row_sum, ckc_pkg::FracBits'(0)};
  assign dext      = {1'b0, div_q};
  assign tx        = {rx_q, dx_q[ckc_pkg::QuoWidth-1]};
  assign ty        = {ry_q, dy_q[ckc_pkg::QuoWidth-1]};
  assign gx        = tx >= dext;
  assign gy        = ty >= dext;
  assign last_step = step_q == ckc_pkg::StepWidth'(ckc_pkg::QuoWidth - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ckc_pkg::BK_IDLE: begin
        if (!empty_i) begin
          state_d = (sums_i.pixel_matches == '0) ? ckc_pkg::BK_OUTPUT : ckc_pkg::BK_DIVIDE;
        end
      end
      ckc_pkg::BK_DIVIDE: begin
        if (last_step) begin
          state_d = ckc_pkg::BK_OUTPUT;
        end
      end
      ckc_pkg::BK_OUTPUT: begin
        if (out_ready_i) begin
          state_d = ckc_pkg::BK_IDLE;
        end
      end
      default: state_d = ckc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ckc_pkg::BK_IDLE:   pop_o = !empty_i;
      ckc_pkg::BK_DIVIDE: pop_o = 1'b0;
      ckc_pkg::BK_OUTPUT: out_valid_o = 1'b1;
      default:            pop_o = 1'b0;
    endcase
  end

  assign load = pop_o;

  assign out_beat_o.centroid_x  = dx_q;
  assign out_beat_o.centroid_y  = dy_q;
  assign out_beat_o.match_count = div_q;
  assign out_beat_o.found       = found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ckc_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // restoring division, one quotient bit per cycle for both axes
  always_ff @(posedge clk_i) begin
    if (load) begin
      div_q   <= sums_i.pixel_matches;
      found_q <= sums_i.pixel_matches != '0;
      step_q  <= '0;
      if (sums_i.pixel_matches == '0) begin
        dx_q <= '0;
        dy_q <= '0;
        rx_q <= '0;
        ry_q <= '0;
      end else begin
        dx_q <= dvx[ckc_pkg::QuoWidth-1:0];
        dy_q <= dvy[ckc_pkg::QuoWidth-1:0];
        rx_q <= dvx[DivWidth-1:ckc_pkg::QuoWidth];
        ry_q <= dvy[DivWidth-1:ckc_pkg::QuoWidth];
      end
    end else if (state_q == ckc_pkg::BK_DIVIDE) begin
      step_q <= step_q + 1'b1;
      dx_q   <= {dx_q[ckc_pkg::QuoWidth-2:0], gx};
      dy_q   <= {dy_q[ckc_pkg::QuoWidth-2:0], gy};
      rx_q   <= gx ? ckc_pkg::CountWidth'(tx - dext) : tx[ckc_pkg::CountWidth-1:0];
      ry_q   <= gy ? ckc_pkg::CountWidth'(ty - dext) : ty[ckc_pkg::CountWidth-1:0];
    end
  end

  a_found_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_q == (div_q != '0)))
    else $error("found flag disagrees with count");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_q) |-> ((dx_q == '0) && (dy_q == '0)))
    else $error("empty frame with nonzero centroid");

endmodule

FILE: sv/color_key_centroid_top.sv
// color key centroid
// input channel: one pixel beat per cycle (bgr, column, row, last_pixel flag),
// valid/ready. output channel: one result beat per frame (centroid_x/y in
// unsigned 11.4 fixed point, truncated, match_count, found), valid/ready.
// config: write cfg_we_i with cfg_index_i (0 red, 1 green, 2 blue,
// 3 tolerance) and cfg_data_i, only while the block is idle.
// a pixel matches when every channel differs from the target by less than
// the tolerance; coordinates at or beyond max side never count.
// throughput: one pixel per cycle, set by the classify and accumulate front.
// the back end pops each frame, runs 15 quotient steps in the restoring
// divider for both axes (skipped when no pixel matched) and then presents the
// result; up to two finished frames wait in the queue between them; frames
// shorter than the back end's work stall the input only at their last pixel.
// when out_ready_i is low the result holds and pixels keep flowing until the
// queue fills. reset clears the sums, the queue and the back-end state and
// loads targets 0 and tolerance 5.
module color_key_centroid_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ckc_pkg::pixel_beat_t  in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ckc_pkg::result_beat_t out_beat_o
);

  ckc_pkg::key_cfg_t    cfg_q, cfg_d;
  ckc_pkg::frame_sums_t push_data, pop_data;
  logic                 push, full, pop, empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ckc_pkg::cfg_reg_e'(cfg_index_i))
        ckc_pkg::CFG_TARGET_RED:   cfg_d.target_red = cfg_data_i;
        ckc_pkg::CFG_TARGET_GREEN: cfg_d.target_green = cfg_data_i;
        ckc_pkg::CFG_TARGET_BLUE:  cfg_d.target_blue = cfg_data_i;
        ckc_pkg::CFG_MATCH_TOL:    cfg_d.match_tolerance = cfg_data_i;
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_red      <= '0;
      cfg_q.target_green    <= '0;
      cfg_q.target_blue     <= '0;
      cfg_q.match_tolerance <= ckc_pkg::TolReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ckc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  ckc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  ckc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sums_i      (pop_data),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

FILE: test/ckc_centroid_checker.sv
module ckc_centroid_checker
  import ckc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i,
  input  logic         in_valid_i,
  input  logic         in_ready_i,
  input  pixel_beat_t  in_beat_i,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  result_beat_t out_beat_i,
  output int           mismatch_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PixelWidth-1:0] key_red;
  logic [PixelWidth-1:0] key_green;
  logic [PixelWidth-1:0] key_blue;
  logic [PixelWidth-1:0] key_tol;
  logic [SumWidth-1:0]   col_sum;
  logic [SumWidth-1:0]   row_sum;
  logic [CountWidth-1:0] hit_count;
  result_beat_t          centroid_queue[$];
  int                    mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic logic channel_near(logic [7:0] pix, logic [7:0] tgt, logic [7:0] tol);
    logic [7:0] gap;
    gap = (pix >= tgt) ? pix - tgt : tgt - pix;
    return gap < tol;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic absorb_pixel(input pixel_beat_t p);
    result_beat_t r;
    logic [63:0]  qx;
    logic [63:0]  qy;
    logic         hit;
    hit = (p.column < MaxSide) && (p.row_index < MaxSide) &&
          channel_near(p.pixel_blue, key_blue, key_tol) &&
          channel_near(p.pixel_green, key_green, key_tol) &&
          channel_near(p.pixel_red, key_red, key_tol);
    if (hit && hit_count != CountMax) begin
      col_sum = col_sum + SumWidth'(p.column);
      row_sum = row_sum + SumWidth'(p.row_index);
      hit_count = hit_count + 1'b1;
    end
    if (p.last_pixel) begin
      r = '0;
      if (hit_count != '0) begin
        qx = (64'(col_sum) << FracBits) / 64'(hit_count);
        qy = (64'(row_sum) << FracBits) / 64'(hit_count);
        r.centroid_x = qx[QuoWidth-1:0];
        r.centroid_y = qy[QuoWidth-1:0];
        r.match_count = hit_count;
        r.found = 1'b1;
      end
      centroid_queue = {centroid_queue, r};
      col_sum = '0;
      row_sum = '0;
      hit_count = '0;
    end
  endtask

  task automatic check_result(input result_beat_t got);
    result_beat_t want;
    if (centroid_queue.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected: %p", got));
      return;
    end
    want = centroid_queue.pop_front();
    if (got.centroid_x !== want.centroid_x)
      report_mismatch($sformatf("centroid_x got %0d want %0d", got.centroid_x,
                                want.centroid_x));
    if (got.centroid_y !== want.centroid_y)
      report_mismatch($sformatf("centroid_y got %0d want %0d", got.centroid_y,
                                want.centroid_y));
    if (got.match_count !== want.match_count)
      report_mismatch($sformatf("match_count got %0d want %0d", got.match_count,
                                want.match_count));
    if (got.found !== want.found)
      report_mismatch($sformatf("found got %0b want %0b", got.found, want.found));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_red = '0;
      key_green = '0;
      key_blue = '0;
      key_tol = TolReset;
      col_sum = '0;
      row_sum = '0;
      hit_count = '0;
      centroid_queue.delete();
      pending_o <= 0;
    end else begin
      // output first so a beat never matches an expectation pushed this edge
      if (out_valid_i && out_ready_i) check_result(out_beat_i);
      if (in_valid_i && in_ready_i) absorb_pixel(in_beat_i);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_TARGET_RED:   key_red = cfg_data_i;
          CFG_TARGET_GREEN: key_green = cfg_data_i;
          CFG_TARGET_BLUE:  key_blue = cfg_data_i;
          CFG_MATCH_TOL:    key_tol = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= centroid_queue.size();
    end
  end

endmodule

FILE: test/color_key_centroid_top_tb.sv
module color_key_centroid_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ckc_pkg::*;

  localparam int unsigned RandomPixels = 600;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 40;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_index_i = CFG_TARGET_RED;
  logic [7:0]   cfg_data_i = '0;
  logic         in_valid_i = 1'b0;
  logic         in_ready_o;
  pixel_beat_t  in_beat_i = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  result_beat_t out_beat_o;
  int           mismatch_count;
  int           pending;

  logic [7:0] key_red = '0;
  logic [7:0] key_green = '0;
  logic [7:0] key_blue = '0;
  logic [7:0] key_tol = TolReset;
  bit         sender_quiet = 1'b0;
  bit         receiver_quiet = 1'b0;
  bit         hold_request = 1'b0;
  int         stall_cycles = 0;
  int         sent = 0;

  color_key_centroid_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  ckc_centroid_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_beat_i        (in_beat_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_beat_i       (out_beat_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("timeout: no beat moved for %0d cycles", StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold
  initial begin
    int waits;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request <= 1'b0;
      end
      if ($urandom_range(0, 7) == 0) receiver_quiet = ~receiver_quiet;
      waits = receiver_quiet ? 0 : $urandom_range(0, 13);
      if (waits > 0) begin
        out_ready_i <= 1'b0;
        repeat (waits) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  function automatic pixel_beat_t make_beat(logic [7:0] red, logic [7:0] green,
                                            logic [7:0] blue, logic [10:0] col,
                                            logic [10:0] row, logic last);
    pixel_beat_t p;
    p.pixel_blue = blue;
    p.pixel_green = green;
    p.pixel_red = red;
    p.column = col;
    p.row_index = row;
    p.last_pixel = last;
    return p;
  endfunction

  function automatic logic [7:0] near_channel(logic [7:0] tgt, logic [7:0] tol);
    int gap;
    int v;
    gap = (tol == 0) ? 0 : $urandom_range(0, tol);
    v = $urandom_range(0, 1) ? int'(tgt) + gap : int'(tgt) - gap;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [10:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 11'd2047;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic pixel_beat_t make_pixel(bit hit, bit last);
    pixel_beat_t p;
    p.pixel_blue = hit ? near_channel(key_blue, key_tol) : 8'($urandom_range(0, 255));
    p.pixel_green = hit ? near_channel(key_green, key_tol) : 8'($urandom_range(0, 255));
    p.pixel_red = hit ? near_channel(key_red, key_tol) : 8'($urandom_range(0, 255));
    p.column = pick_coord();
    p.row_index = pick_coord();
    p.last_pixel = last;
    return p;
  endfunction

  task automatic send_pixel(input pixel_beat_t p);
    int waits;
    if ($urandom_range(0, 31) == 0) sender_quiet = ~sender_quiet;
    waits = sender_quiet ? 0 : $urandom_range(0, 13);
    if (waits > 0) begin
      in_valid_i <= 1'b0;
      repeat (waits) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= p;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sent++;
  endtask

  task automatic send_frame(input int len, input int hit_pct);
    for (int i = 0; i < len; i++) begin
      send_pixel(make_pixel($urandom_range(0, 99) < hit_pct, i == len - 1));
    end
  endtask

  // wait until every frame result is out and the back end has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_key(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [7:0] tol);
    settle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_TARGET_RED;
    cfg_data_i <= red;
    @(posedge clk_i);
    cfg_index_i <= CFG_TARGET_GREEN;
    cfg_data_i <= green;
    @(posedge clk_i);
    cfg_index_i <= CFG_TARGET_BLUE;
    cfg_data_i <= blue;
    @(posedge clk_i);
    cfg_index_i <= CFG_MATCH_TOL;
    cfg_data_i <= tol;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_red = red;
    key_green = green;
    key_blue = blue;
    key_tol = tol;
  endtask

  function automatic logic [7:0] pick_target();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int phase;
    int len;
    int frames;
    logic [7:0] tol;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key: black, tolerance 5; extreme coordinates
    send_pixel(make_beat(0, 0, 0, 0, 0, 0));
    send_pixel(make_beat(4, 4, 4, 2047, 2047, 1));
    // empty frames, each channel exactly at the tolerance
    send_pixel(make_beat(5, 0, 0, 100, 100, 1));
    send_pixel(make_beat(0, 5, 0, 7, 9, 0));
    send_pixel(make_beat(0, 0, 5, 9, 7, 1));
    // white key, widest tolerance
    program_key(255, 255, 255, 255);
    send_pixel(make_beat(0, 0, 0, 7, 7, 0));
    send_pixel(make_beat(1, 1, 1, 2047, 0, 0));
    send_pixel(make_beat(255, 255, 255, 0, 2047, 1));
    // zero tolerance matches nothing
    program_key(255, 255, 255, 0);
    send_pixel(make_beat(255, 255, 255, 12, 34, 1));
    // tolerance 1: only exact colors, one channel off by one misses
    program_key(128, 64, 32, 1);
    send_pixel(make_beat(128, 64, 32, 3, 5, 0));
    send_pixel(make_beat(129, 64, 32, 11, 13, 0));
    send_pixel(make_beat(128, 63, 32, 17, 19, 0));
    send_pixel(make_beat(128, 64, 33, 23, 29, 0));
    send_pixel(make_beat(128, 64, 32, 1000, 1999, 1));

    sent = 0;
    phase = 0;
    while (sent < RandomPixels) begin
      case ($urandom_range(0, 7))
        0: tol = 8'd0;
        1: tol = 8'd255;
        2: tol = 8'($urandom_range(1, 3));
        default: tol = 8'($urandom_range(4, 60));
      endcase
      program_key(pick_target(), pick_target(), pick_target(), tol);
      if (phase == 2) begin
        // result side stalls while short frames keep arriving
        hold_request <= 1'b1;
        sender_quiet = 1'b1;
        for (int f = 0; f < 12; f++) send_frame($urandom_range(1, 3), 80);
      end else begin
        frames = $urandom_range(3, 8);
        for (int f = 0; f < frames; f++) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
          send_frame(len, 75);
        end
      end
      phase++;
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ckc_pkg.sv
sv/ckc_front.sv
sv/ckc_queue.sv
sv/ckc_back.sv
sv/color_key_centroid_top.sv
test/ckc_centroid_checker.sv
test/color_key_centroid_top_tb.sv
